### hdl/ssrg_pkg.sv
`timescale 1ns / 1ps

package ssrg_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_AMPLITUDE = 2'd1;
    localparam logic [1:0] CFG_DELAY     = 2'd2;
    localparam logic [1:0] CFG_RATE      = 2'd3;

    // waveform select
    localparam logic MODE_STEP = 1'b0;

    // fixed stage counts of the phase front end and the output scaler
    localparam int PH_STAGES = 6;
    localparam int SC_STAGES = 2;

    // cordic datapath widths
    localparam int XW = 33;
    localparam int ZW = 34;

    localparam logic signed [XW-1:0] CORDIC_X0  = 33'sd652032874;
    localparam logic signed [33:0]   TWO_PI_Q30 = 34'sd6746518852;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127
    };

    typedef struct packed {
        logic               mode;
        logic signed [15:0] amplitude;
        logic [31:0]        step_delay_ms;
        logic [15:0]        angular_rate;
    } t_cfg;

    // round(2^pb / (2000*pi)) by restoring long division, elaboration only
    function automatic logic [63:0] phase_gain(input int pb);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = 64'd1000000000000;
        quo = 64'd0;
        for (int i = 0; i < pb + 1; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= 64'd6283185307179586) begin
                rem = rem - 64'd6283185307179586;
                quo = quo | 64'd1;
            end
        end
        return (quo + 64'd1) >> 1;
    endfunction

endpackage

### hdl/ssrg_pipe_ctrl.sv
`timescale 1ns / 1ps

module ssrg_pipe_ctrl #(
    parameter int DEPTH = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output logic [DEPTH-1:0] o_en
);

    logic [DEPTH-1:0] r_v;
    logic [DEPTH-1:0] n_v;
    logic [DEPTH-1:0] w_en;

    // a stage moves when the output drains or a bubble sits at or after it
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            w_en[k] = i_out_ready || ((~r_v >> k) != '0);
        end
    end

    always_comb begin
        n_v = r_v;
        if (w_en[0]) begin
            n_v[0] = i_in_valid;
        end
        for (int k = 1; k < DEPTH; k++) begin
            if (w_en[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_en        = w_en;
    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[DEPTH-1];

endmodule

### hdl/ssrg_phase.sv
`timescale 1ns / 1ps

module ssrg_phase
    import ssrg_pkg::*;
#(
    parameter int PHASE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic [PH_STAGES-1:0] i_en,
    input  t_cfg                 i_cfg,
    input  logic [31:0]          i_elapsed_ms,
    output logic signed [31:0]   o_z,
    output logic                 o_on
);

    localparam logic [63:0] K_FULL = phase_gain(PHASE_BITS);
    localparam int KW  = $clog2(K_FULL + 64'd1);
    localparam logic [KW-1:0] K = KW'(K_FULL);
    localparam int HA  = (PHASE_BITS + 1) / 2;
    localparam int HB  = PHASE_BITS - HA;
    localparam int PLW = HA + KW;
    localparam int PHW = HB + KW;

    logic [PHASE_BITS-1:0]   r_p1;
    logic [PHASE_BITS-1:0]   r_pl;
    logic [PHASE_BITS-1:0]   r_ph;
    logic [31:0]             r_t32;
    logic signed [31:0]      r_tf;
    logic signed [65:0]      r_prod;
    logic signed [31:0]      r_z;
    logic [PH_STAGES-1:0]    r_on;

    logic [47:0]             w_p1;
    logic [PLW-1:0]          w_pl;
    logic [PHW-1:0]          w_ph;
    logic [PHASE_BITS-1:0]   w_phase;
    logic [31:0]             w_t32;
    logic signed [32:0]      w_ts;
    logic signed [32:0]      w_tf;
    logic signed [65:0]      w_prod;
    logic signed [65:0]      w_zsum;

    // time times rate, only the low phase bits survive the wrap
    assign w_p1 = 48'(i_elapsed_ms) * 48'(i_cfg.angular_rate);

    // gain multiply split into two partial products
    assign w_pl = PLW'(r_p1[HA-1:0]) * PLW'(K);
    assign w_ph = PHW'(r_p1[PHASE_BITS-1:HA]) * PHW'(K);

    assign w_phase = r_pl + (r_ph << HA);

    generate
        if (PHASE_BITS >= 32) begin : g_trunc
            assign w_t32 = w_phase[PHASE_BITS-1 -: 32];
        end else begin : g_fill
            assign w_t32 = {w_phase, {(32 - PHASE_BITS){1'b0}}};
        end
    endgenerate

    // fold into a quarter turn either side of zero
    assign w_ts = $signed({r_t32[31], r_t32});
    always_comb begin
        if (w_ts > 33'sd1073741824) begin
            w_tf = 33'sd2147483648 - w_ts;
        end else if (w_ts < -33'sd1073741824) begin
            w_tf = -33'sd2147483648 - w_ts;
        end else begin
            w_tf = w_ts;
        end
    end

    // turns to radians q30, rounded
    assign w_prod = 66'(r_tf) * 66'(TWO_PI_Q30);
    assign w_zsum = r_prod + 66'sd2147483648;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p1    <= w_p1[PHASE_BITS-1:0];
            r_on[0] <= (i_elapsed_ms >= i_cfg.step_delay_ms);
        end
        if (i_en[1]) begin
            r_pl    <= PHASE_BITS'(w_pl);
            r_ph    <= PHASE_BITS'(w_ph);
            r_on[1] <= r_on[0];
        end
        if (i_en[2]) begin
            r_t32   <= w_t32;
            r_on[2] <= r_on[1];
        end
        if (i_en[3]) begin
            r_tf    <= w_tf[31:0];
            r_on[3] <= r_on[2];
        end
        if (i_en[4]) begin
            r_prod  <= w_prod;
            r_on[4] <= r_on[3];
        end
        if (i_en[5]) begin
            r_z     <= w_zsum[63:32];
            r_on[5] <= r_on[4];
        end
    end

    assign o_z  = r_z;
    assign o_on = r_on[PH_STAGES-1];

endmodule

### hdl/ssrg_cordic.sv
`timescale 1ns / 1ps

module ssrg_cordic
    import ssrg_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  logic                 i_clk,
    input  logic [STAGES-1:0]    i_en,
    input  logic signed [31:0]   i_z,
    input  logic                 i_on,
    output logic signed [XW-1:0] o_y,
    output logic                 o_on
);

    logic signed [XW-1:0] r_x  [STAGES];
    logic signed [XW-1:0] r_y  [STAGES];
    logic signed [ZW-1:0] r_z  [STAGES];
    logic                 r_on [STAGES];

    generate
        for (genvar g = 0; g < STAGES; g++) begin : g_stage
            logic signed [XW-1:0] w_xi;
            logic signed [XW-1:0] w_yi;
            logic signed [ZW-1:0] w_zi;
            logic                 w_oi;
            logic signed [ZW-1:0] w_atan;

            if (g == 0) begin : g_first
                assign w_xi = CORDIC_X0;
                assign w_yi = '0;
                assign w_zi = ZW'(i_z);
                assign w_oi = i_on;
            end else begin : g_next
                assign w_xi = r_x[g-1];
                assign w_yi = r_y[g-1];
                assign w_zi = r_z[g-1];
                assign w_oi = r_on[g-1];
            end

            assign w_atan = $signed(ZW'(ATAN_Q30[g]));

            // rotate towards zero angle
            always_ff @(posedge i_clk) begin
                if (i_en[g]) begin
                    r_on[g] <= w_oi;
                    if (!w_zi[ZW-1]) begin
                        r_x[g] <= w_xi - (w_yi >>> g);
                        r_y[g] <= w_yi + (w_xi >>> g);
                        r_z[g] <= w_zi - w_atan;
                    end else begin
                        r_x[g] <= w_xi + (w_yi >>> g);
                        r_y[g] <= w_yi - (w_xi >>> g);
                        r_z[g] <= w_zi + w_atan;
                    end
                end
            end
        end
    endgenerate

    assign o_y  = r_y[STAGES-1];
    assign o_on = r_on[STAGES-1];

endmodule

### hdl/ssrg_scale.sv
`timescale 1ns / 1ps

module ssrg_scale
    import ssrg_pkg::*;
(
    input  logic                 i_clk,
    input  logic [SC_STAGES-1:0] i_en,
    input  t_cfg                 i_cfg,
    input  logic signed [XW-1:0] i_y,
    input  logic                 i_on,
    output logic signed [15:0]   o_speed
);

    localparam int PW = XW + 16;

    logic signed [PW-1:0] r_p;
    logic                 r_on;
    logic signed [15:0]   r_speed;

    logic signed [PW-1:0] w_p;
    logic signed [PW-1:0] w_sum;
    logic signed [PW-31:0] w_q;
    logic signed [15:0]   w_sat;
    logic signed [15:0]   w_speed;

    assign w_p = PW'(i_y) * PW'(i_cfg.amplitude);

    // halves away from zero: negative values add one less before the floor shift
    assign w_sum = r_p + (r_p[PW-1] ? PW'(30'sd536870911) : PW'(31'sd536870912));
    assign w_q   = w_sum[PW-1:30];

    always_comb begin
        if (w_q > (PW-30)'(32767)) begin
            w_sat = 16'sd32767;
        end else if (w_q < -(PW-30)'(32768)) begin
            w_sat = -16'sd32768;
        end else begin
            w_sat = w_q[15:0];
        end
    end

    always_comb begin
        if (i_cfg.mode == MODE_STEP) begin
            w_speed = r_on ? i_cfg.amplitude : '0;
        end else begin
            w_speed = w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p  <= w_p;
            r_on <= i_on;
        end
        if (i_en[1]) begin
            r_speed <= w_speed;
        end
    end

    assign o_speed = r_speed;

endmodule

### hdl/step_sine_reference_generator.sv
// throughput: one item per cycle unless back-pressure on the output fills the pipe; every stage
// of the phase front end, the cordic rotations and the output scaler is its own register stage
// reset: synchronous, active low; clears the configuration registers and all
// stage valid bits, the datapath registers are not reset
`timescale 1ns / 1ps

module step_sine_reference_generator
    import ssrg_pkg::*;
#(
    parameter int PHASE_BITS    = 32,
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // time input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_elapsed_ms,
    // speed output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_speed
);

    // total register stages, the last one being the output register
    localparam int DEPTH = PH_STAGES + CORDIC_STAGES + SC_STAGES;

    logic               r_mode;
    logic signed [15:0] r_amplitude;
    logic [31:0]        r_step_delay_ms;
    logic [15:0]        r_angular_rate;

    t_cfg               w_cfg;
    logic [DEPTH-1:0]   w_en;
    logic signed [31:0] w_z;
    logic               w_on_ph;
    logic signed [XW-1:0] w_y;
    logic               w_on_cd;

    // configuration registers; the user writes them only while the pipe is empty, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= 1'b0;
            r_amplitude     <= '0;
            r_step_delay_ms <= '0;
            r_angular_rate  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:      r_mode          <= i_cfg_data[0];
                CFG_AMPLITUDE: r_amplitude     <= i_cfg_data[15:0];
                CFG_DELAY:     r_step_delay_ms <= i_cfg_data;
                CFG_RATE:      r_angular_rate  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.mode          = r_mode;
    assign w_cfg.amplitude     = r_amplitude;
    assign w_cfg.step_delay_ms = r_step_delay_ms;
    assign w_cfg.angular_rate  = r_angular_rate;

    // valid bits and per-stage enables; a stage only holds when everything
    // from it downstream, itself included, is full and the output transfer is not taken
    ssrg_pipe_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_en        (w_en)
    );

    // time to folded angle in radians q30; the step compare rides along as one bit
    ssrg_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .i_clk        (i_clk),
        .i_en         (w_en[PH_STAGES-1:0]),
        .i_cfg        (w_cfg),
        .i_elapsed_ms (i_elapsed_ms),
        .o_z          (w_z),
        .o_on         (w_on_ph)
    );

    // one rotation per stage, sine comes out in q30
    ssrg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk (i_clk),
        .i_en  (w_en[PH_STAGES +: CORDIC_STAGES]),
        .i_z   (w_z),
        .i_on  (w_on_ph),
        .o_y   (w_y),
        .o_on  (w_on_cd)
    );

    // amplitude multiply, rounding, saturation and the step/sine select
    ssrg_scale u_scale (
        .i_clk   (i_clk),
        .i_en    (w_en[PH_STAGES + CORDIC_STAGES +: SC_STAGES]),
        .i_cfg   (w_cfg),
        .i_y     (w_y),
        .i_on    (w_on_cd),
        .o_speed (o_speed)
    );

endmodule

### hdl/ssrg_checker.sv
`timescale 1ns / 1ps

module ssrg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_speed
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_speed))
        else $error("result dropped or changed while stalled");

    // the input side only stalls behind a waiting result
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipe");

    // a drained output always frees the input
    a_ready_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input not ready while output drains");

endmodule

bind step_sine_reference_generator ssrg_checker u_ssrg_checker (.*);

### dv/step_sine_reference_generator_test.sv
`timescale 1ns / 1ps

// checks the step / sine speed generator against a behavioural copy of its
// arithmetic: every time value offered to the block is turned into a predicted
// speed at the transfer, queued, and compared with the block's output in order
module step_sine_reference_generator_test;
    import ssrg_pkg::*;

    // input transfer to result, plus some slack when waiting for stragglers
    localparam int PIPE_DEPTH    = 16 + 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PERCENT  = 9;
    localparam int RANDOM_PHASES = 30;
    localparam int PHASE_ITEMS   = 60;
    localparam int PROBE_ROWS    = 24;

    localparam logic MODE_SINE = ~MODE_STEP;

    // phase advance per ms per rad/s, as a 32-bit fraction of a turn:
    // round(2^32 / (2000*pi)) done as one wide integer division
    localparam logic [127:0] TURN_GAIN_X2 =
        ((128'd1 << 33) * 128'd1000000000000) / 128'd6283185307179586;
    localparam logic [31:0] TURN_GAIN = 32'((TURN_GAIN_X2 + 128'd1) >> 1);

    // quarter turn as a 32-bit phase, and the same in signed 64-bit terms
    localparam logic [31:0] QTR_TURN  = 32'h4000_0000;
    localparam longint      QTR_S     = 64'sd1073741824;
    localparam longint      HALF_S    = 64'sd2147483648;
    // 2*pi in Q30, unit start vector after cordic gain, rounding constants
    localparam longint      RAD_Q30   = 64'sd6746518852;
    localparam longint      START_X   = 64'sd652032874;
    localparam longint      ROUND_Q30 = 64'sd536870912;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [31:0]        i_elapsed_ms;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_speed;

    step_sine_reference_generator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_elapsed_ms (i_elapsed_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_speed      (o_speed)
    );

    // floor(atan(2^-i) * 2^30) for the sixteen rotations
    longint atan_q30_tab [16] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
        64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
        64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
        64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767
    };

    // one directed probe: the register setting it needs, the time (or the
    // phase to land on, for odd rates) and, where obvious, the speed itself
    typedef struct packed {
        logic               md;
        logic signed [15:0] amp;
        logic [31:0]        dly;
        logic [15:0]        rate;
        logic               by_turn;
        logic [31:0]        stamp;
        logic               pinned;
        logic signed [15:0] speed;
    } t_probe;

    t_probe probe_list [PROBE_ROWS] = '{
        // registers straight out of reset
        '{MODE_STEP, 16'sd0, 32'd0, 16'd0, 1'b0, 32'd0, 1'b1, 16'sd0},
        '{MODE_STEP, 16'sd0, 32'd0, 16'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 16'sd0},
        // step edge: one ms short, exactly on the delay, far past it
        '{MODE_STEP, 16'sh7FFF, 32'd1000, 16'd0, 1'b0, 32'd999, 1'b1, 16'sd0},
        '{MODE_STEP, 16'sh7FFF, 32'd1000, 16'd0, 1'b0, 32'd1000, 1'b1, 16'sh7FFF},
        '{MODE_STEP, 16'sh7FFF, 32'd1000, 16'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 16'sh7FFF},
        // largest delay, most negative amplitude
        '{MODE_STEP, 16'sh8000, 32'hFFFF_FFFF, 16'd0, 1'b0, 32'hFFFF_FFFE, 1'b1, 16'sd0},
        '{MODE_STEP, 16'sh8000, 32'hFFFF_FFFF, 16'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 16'sh8000},
        '{MODE_STEP, 16'sh8000, 32'hFFFF_FFFF, 16'd0, 1'b0, 32'd0, 1'b1, 16'sd0},
        '{MODE_STEP, -16'sd1, 32'd0, 16'd0, 1'b0, 32'd0, 1'b1, -16'sd1},
        // zero rate keeps the phase at zero, the cordic residue decides the rest
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'd0, 1'b0, 32'd12345, 1'b0, 16'sd0},
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        // zero amplitude
        '{MODE_SINE, 16'sd0, 32'd0, 16'd1, 1'b0, 32'd777, 1'b1, 16'sd0},
        // quarter turns and the fold boundaries either side of them
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'd1, 1'b1, 32'd0, 1'b0, 16'sd0},
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'd1, 1'b1, QTR_TURN, 1'b0, 16'sd0},
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'd1, 1'b1, QTR_TURN + 32'd1, 1'b0, 16'sd0},
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'd1, 1'b1, 2 * QTR_TURN, 1'b0, 16'sd0},
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'd1, 1'b1, 3 * QTR_TURN, 1'b0, 16'sd0},
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'd1, 1'b1, 3 * QTR_TURN - 32'd1, 1'b0, 16'sd0},
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'd1, 1'b1, 3 * QTR_TURN + 32'd1, 1'b0, 16'sd0},
        // sine trough times the most negative amplitude overshoots and saturates
        '{MODE_SINE, 16'sh8000, 32'd0, 16'd1, 1'b1, 3 * QTR_TURN, 1'b0, 16'sd0},
        '{MODE_SINE, 16'sh8000, 32'd0, 16'd1, 1'b1, QTR_TURN, 1'b0, 16'sd0},
        // fastest rate at the time extremes
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        '{MODE_SINE, 16'sh7FFF, 32'd0, 16'hFFFF, 1'b0, 32'd1, 1'b0, 16'sd0},
        '{MODE_SINE, 16'sh8000, 32'd0, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 16'sd0}
    };

    // register copy seen by the predictor, updated on the write edge
    logic               sh_mode;
    logic signed [15:0] sh_amp;
    logic [31:0]        sh_delay;
    logic [15:0]        sh_rate;

    // setting last programmed, as the stimulus side knows it
    logic               cur_mode;
    logic signed [15:0] cur_amp;
    logic [31:0]        cur_delay;
    logic [15:0]        cur_rate;

    // speeds still owed by the block, oldest first
    logic signed [15:0] speed_due [$];

    // a typed-in speed travels with the time value it belongs to
    logic               pin_on;
    logic signed [15:0] pin_speed;

    int          fail_count;
    int unsigned cycle_count;
    bit          steady;
    bit          hold_req;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = ~i_clk;
    end

    // y of the rotation in Q30 for the given time and rate
    function automatic longint cordic_sine(input logic [31:0] t_ms, input logic [15:0] rate);
        logic [31:0] turn;
        longint      ang;
        longint      z;
        longint      x;
        longint      y;
        longint      xn;
        // low 32 bits only: the wrap is a whole number of turns
        turn = t_ms * 32'(rate) * TURN_GAIN;
        ang  = longint'($signed(turn));
        // fold into [-1/4, +1/4] turn, sin(x) = sin(pi - x)
        if (ang > QTR_S) begin
            ang = HALF_S - ang;
        end else if (ang < -QTR_S) begin
            ang = -HALF_S - ang;
        end
        z = (ang * RAD_Q30 + HALF_S) >>> 32;
        x = START_X;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_q30_tab[i];
            end else begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_q30_tab[i];
            end
            x = xn;
        end
        return y;
    endfunction

    // speed the block owes for one time value under the current registers
    function automatic logic signed [15:0] predict_speed(input logic [31:0] t_ms);
        longint prod;
        longint spd;
        if (sh_mode == MODE_STEP) begin
            return (t_ms >= sh_delay) ? sh_amp : 16'sd0;
        end
        prod = cordic_sine(t_ms, sh_rate) * longint'(sh_amp);
        // round half away from zero, then clamp
        if (prod >= 0) begin
            spd = (prod + ROUND_Q30) >>> 30;
        end else begin
            spd = -((-prod + ROUND_Q30) >>> 30);
        end
        if (spd > 32767) begin
            spd = 32767;
        end else if (spd < -32768) begin
            spd = -32768;
        end
        return 16'(spd);
    endfunction

    // time that lands the phase exactly on a wanted turn fraction; the rate
    // must be odd so that rate * gain has an inverse modulo 2^32
    function automatic logic [31:0] time_for_turn(input logic [31:0] turn,
                                                  input logic [15:0] rate);
        logic [31:0] m;
        logic [31:0] inv;
        m   = 32'(rate) * TURN_GAIN;
        inv = m;
        // newton steps double the correct low bits each time
        repeat (5) begin
            inv = inv * (32'd2 - m * inv);
        end
        return turn * inv;
    endfunction

    // scoreboard: check results, queue predictions, track register writes
    always @(posedge i_clk) begin
        logic signed [15:0] due;
        if (!i_rst_n) begin
            sh_mode  = MODE_STEP;
            sh_amp   = '0;
            sh_delay = '0;
            sh_rate  = '0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (speed_due.size() == 0) begin
                    $error("speed: no result outstanding, got %0d", o_speed);
                    fail_count++;
                end else begin
                    due = speed_due.pop_front();
                    if (o_speed !== due) begin
                        $error("speed: expected %0d, actual %0d", due, o_speed);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                speed_due.push_back(pin_on ? pin_speed : predict_speed(i_elapsed_ms));
            end
            // registers keep only their own width of the data word
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:      sh_mode  = i_cfg_data[0];
                    CFG_AMPLITUDE: sh_amp   = i_cfg_data[15:0];
                    CFG_DELAY:     sh_delay = i_cfg_data;
                    CFG_RATE:      sh_rate  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // run time guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // output side: random back-pressure, or one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic put_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // wait for every owed speed with the input side quiet; the first wait lets
    // the scoreboard queue the transfer taken on this very edge
    task automatic wait_all_due();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (speed_due.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // program a new setting once idle; unused high data bits carry noise
    task automatic reprogram(input logic md, input logic signed [15:0] amp,
                             input logic [31:0] dly, input logic [15:0] rate);
        logic [31:0] noise;
        noise = $urandom();
        wait_all_due();
        put_reg(CFG_MODE, {noise[31:1], md});
        put_reg(CFG_AMPLITUDE, {noise[15:0], amp});
        put_reg(CFG_DELAY, dly);
        put_reg(CFG_RATE, {noise[31:16], rate});
        i_cfg_we  <= 1'b0;
        cur_mode  = md;
        cur_amp   = amp;
        cur_delay = dly;
        cur_rate  = rate;
    endtask

    // offer one time value, with random idle cycles ahead of it
    task automatic offer_time(input logic [31:0] t_ms, input logic pinned,
                              input logic signed [15:0] speed);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_elapsed_ms <= t_ms;
        pin_on       <= pinned;
        pin_speed    <= speed;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    initial begin
        t_probe             row;
        logic [31:0]        t_ms;
        logic               md;
        logic signed [15:0] amp;
        logic [31:0]        dly;
        logic [15:0]        rate;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_MODE;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_elapsed_ms = '0;
        pin_on       = 1'b0;
        pin_speed    = '0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        fail_count   = 0;
        cycle_count  = 0;
        cur_mode     = MODE_STEP;
        cur_amp      = '0;
        cur_delay    = '0;
        cur_rate     = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed probes: reprogram only when the row asks for another setting
        for (int r = 0; r < PROBE_ROWS; r++) begin
            row = probe_list[r];
            if (row.md !== cur_mode || row.amp !== cur_amp ||
                row.dly !== cur_delay || row.rate !== cur_rate) begin
                reprogram(row.md, row.amp, row.dly, row.rate);
            end
            t_ms = row.by_turn ? time_for_turn(row.stamp, row.rate) : row.stamp;
            offer_time(t_ms, row.pinned, row.speed);
        end

        // random phases, each under a fresh setting with extremes weighted in
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            md = 1'($urandom_range(1));
            case ($urandom_range(5))
                0:       amp = 16'sh8000;
                1:       amp = 16'sh7FFF;
                2:       amp = 16'sd0;
                3:       amp = -16'sd1;
                default: amp = 16'($urandom());
            endcase
            case ($urandom_range(3))
                0:       dly = '0;
                1:       dly = '1;
                2:       dly = $urandom_range(20000);
                default: dly = $urandom();
            endcase
            case ($urandom_range(5))
                0:       rate = '0;
                1:       rate = 16'hFFFF;
                2:       rate = 16'd1;
                default: rate = 16'($urandom());
            endcase
            reprogram(md, amp, dly, rate);
            // one phase runs with no idling on either side
            steady = (p == 4);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // output stalls for a long stretch while inputs keep coming
                if (p == 12 && k == 8) begin
                    hold_req = 1'b1;
                end
                case ($urandom_range(4))
                    0: t_ms = $urandom();
                    1: t_ms = cur_delay + $urandom_range(16) - 32'd8;
                    2: t_ms = $urandom_range(20000);
                    default: begin
                        // near a quarter turn where the rate allows aiming
                        if (cur_rate[0]) begin
                            t_ms = time_for_turn(QTR_TURN * $urandom_range(3) +
                                                 $urandom_range(4) - 32'd2, cur_rate);
                        end else begin
                            t_ms = $urandom();
                        end
                    end
                endcase
                offer_time(t_ms, 1'b0, 16'sd0);
            end
        end

        wait_all_due();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (fail_count == 0 && speed_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
